>>> rtl/core/eaicf_pkg.sv
package eaicf_pkg;

	// Default frame length limit
	localparam int MAX_FRAME_BYTES_DEF = 2048;

	// Configuration registers
	localparam int CFG_W = 48;
	localparam logic REG_OWN_IP  = 1'b0;
	localparam logic REG_OWN_MAC = 1'b1;

	// Protocol constants
	localparam logic [15:0] ETHERTYPE_ARP   = 16'h0806;
	localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
	localparam logic [15:0] ARP_HW_ETH      = 16'h0001;
	localparam logic [15:0] ARP_OP_REQUEST  = 16'h0001;
	localparam logic [15:0] ARP_OP_REPLY    = 16'h0002;
	localparam logic [7:0]  ARP_HW_LEN      = 8'd6;
	localparam logic [7:0]  ARP_PROTO_LEN   = 8'd4;
	localparam logic [7:0]  IPPROTO_ICMP    = 8'd1;
	localparam logic [7:0]  ICMP_ECHO_REPLY = 8'd0;
	localparam logic [3:0]  IHL_MASK        = 4'hF;

	// Reply frame
	localparam int REPLY_BYTES = 42;
	localparam int REPLY_W     = REPLY_BYTES * 8;

	typedef enum logic [1:0] {
		KIND_IGNORE = 2'd0,
		KIND_REPLY  = 2'd1,
		KIND_LEARN  = 2'd2,
		KIND_ECHO   = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0]  rx_byte;
		logic        rx_last;
		logic [31:0] now_tick;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  tx_byte;
		logic        tx_last;
		logic [31:0] peer_ip;
		logic [47:0] peer_mac;
		logic [15:0] echo_ident;
		logic [15:0] echo_seq;
		logic [31:0] rx_tick;
	} result_t;

endpackage

>>> rtl/core/ethernet_arp_icmp_frame_classifier_core.sv
// Flow: a frame's decision is held in the decision stage after its last byte is accepted until it is
//   taken, and the result word is registered in the output register; a reply frame streams from the shift register.
// Throughput: one byte per cycle; the input stalls only while a decided frame waits, for the
//   output register or for a 42-byte reply frame still streaming out of the shift register.
// Reset: arst_n clears the byte counter, all captured header fields, the configuration
//   registers and the valid flags of the decision stage, reply counter and output register.
module ethernet_arp_icmp_frame_classifier_core
	import eaicf_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  item_t            item,
	output logic             res_valid,
	input  logic             res_ready,
	output result_t          res,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int CMP_W = ((CNT_W > 16) ? CNT_W : 16) + 1;
	localparam int RCNT_W = $clog2(REPLY_BYTES + 1);

	// Configuration
	logic [31:0] own_ip_q;
	logic [47:0] own_mac_q;

	// Frame capture state
	logic [CNT_W-1:0] byte_count_q;
	logic [47:0] eth_source_mac_q;
	logic [15:0] ether_type_q;
	logic [15:0] arp_hw_type_q;
	logic [15:0] arp_proto_type_q;
	logic [15:0] arp_operation_q;
	logic [47:0] arp_sender_mac_q;
	logic [31:0] arp_sender_ip_q;
	logic [31:0] arp_target_ip_q;
	logic [3:0]  ip_header_words_q;
	logic [7:0]  ip_protocol_q;
	logic [15:0] ip_total_length_q;
	logic [31:0] ip_source_q;
	logic [7:0]  icmp_type_seen_q;
	logic [15:0] icmp_ident_seen_q;
	logic [15:0] icmp_seq_seen_q;

	// Decision stage
	logic             pend_vld_s1;
	logic [CNT_W-1:0] pend_pos_s1;
	logic             pend_big_s1;
	logic [31:0]      pend_tick_s1;

	// Reply streaming
	logic [REPLY_W-1:0] rep_sr_q;
	logic [RCNT_W-1:0]  rep_cnt_q;

	// Output register
	logic    res_valid_q;
	result_t res_q;

	logic             item_acc;
	logic             cap_en;
	logic [CNT_W-1:0] pos;
	logic [7:0]       b;
	logic [3:0]       ihl_nxt;
	logic [6:0]       off;
	logic [6:0]       off4;
	logic [6:0]       off6;
	logic             rep_busy;
	logic             slot_free;
	logic             rep_emit;
	logic             pend_take;
	kind_t            action;
	result_t          single;
	result_t          rep_word;
	logic [REPLY_W-1:0] reply_frame;

	function automatic logic in_rng(logic [CNT_W-1:0] p, logic [CNT_W-1:0] lo,
		logic [CNT_W-1:0] hi);
		return (p >= lo) && (p <= hi);
	endfunction

	// Handshake control
	assign rep_busy   = (rep_cnt_q != '0);
	assign slot_free  = !res_valid_q || res_ready;
	assign rep_emit   = rep_busy && slot_free;
	assign pend_take  = pend_vld_s1 && !rep_busy && slot_free;
	assign item_ready = !pend_vld_s1 || pend_take;
	assign item_acc   = item_valid && item_ready;

	// Capture position of this byte
	assign pos    = byte_count_q;
	assign b      = item.rx_byte;
	assign cap_en = item_acc && (byte_count_q < CNT_W'(MAX_FRAME_BYTES));

	// ICMP offset follows the header length captured at this very byte
	assign ihl_nxt = (cap_en && (pos == CNT_W'(14))) ? (b[3:0] & IHL_MASK) : ip_header_words_q;
	assign off     = 7'd14 + {1'b0, ihl_nxt, 2'b00};
	assign off4    = off + 7'd4;
	assign off6    = off + 7'd6;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q  <= '0;
			own_mac_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OWN_IP:  own_ip_q  <= cfg_wdata[31:0];
				REG_OWN_MAC: own_mac_q <= cfg_wdata[47:0];
				default: ;
			endcase
		end
	end

	// Count bytes and capture header fields; the first bytes of a frame capture nothing,
	// so a new frame may start while the previous decision is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q      <= '0;
			eth_source_mac_q  <= '0;
			ether_type_q      <= '0;
			arp_hw_type_q     <= '0;
			arp_proto_type_q  <= '0;
			arp_operation_q   <= '0;
			arp_sender_mac_q  <= '0;
			arp_sender_ip_q   <= '0;
			arp_target_ip_q   <= '0;
			ip_header_words_q <= '0;
			ip_protocol_q     <= '0;
			ip_total_length_q <= '0;
			ip_source_q       <= '0;
			icmp_type_seen_q  <= '0;
			icmp_ident_seen_q <= '0;
			icmp_seq_seen_q   <= '0;
		end else begin
			if (item_acc) begin
				if (item.rx_last) begin
					byte_count_q <= '0;
				end else if (byte_count_q < CNT_W'(MAX_FRAME_BYTES)) begin
					byte_count_q <= byte_count_q + 1'b1;
				end
			end
			if (cap_en) begin
				if (in_rng(pos, CNT_W'(6), CNT_W'(11)))
					eth_source_mac_q <= {eth_source_mac_q[39:0], b};
				if (in_rng(pos, CNT_W'(12), CNT_W'(13)))
					ether_type_q <= {ether_type_q[7:0], b};
				if (in_rng(pos, CNT_W'(14), CNT_W'(15)))
					arp_hw_type_q <= {arp_hw_type_q[7:0], b};
				if (in_rng(pos, CNT_W'(16), CNT_W'(17))) begin
					arp_proto_type_q  <= {arp_proto_type_q[7:0], b};
					ip_total_length_q <= {ip_total_length_q[7:0], b};
				end
				if (in_rng(pos, CNT_W'(20), CNT_W'(21)))
					arp_operation_q <= {arp_operation_q[7:0], b};
				if (in_rng(pos, CNT_W'(22), CNT_W'(27)))
					arp_sender_mac_q <= {arp_sender_mac_q[39:0], b};
				if (in_rng(pos, CNT_W'(28), CNT_W'(31)))
					arp_sender_ip_q <= {arp_sender_ip_q[23:0], b};
				if (in_rng(pos, CNT_W'(38), CNT_W'(41)))
					arp_target_ip_q <= {arp_target_ip_q[23:0], b};
				ip_header_words_q <= ihl_nxt;
				if (pos == CNT_W'(23))
					ip_protocol_q <= b;
				if (in_rng(pos, CNT_W'(26), CNT_W'(29)))
					ip_source_q <= {ip_source_q[23:0], b};
				if (pos == CNT_W'(off))
					icmp_type_seen_q <= b;
				if (in_rng(pos, CNT_W'(off4), CNT_W'(off4 + 7'd1)))
					icmp_ident_seen_q <= {icmp_ident_seen_q[7:0], b};
				if (in_rng(pos, CNT_W'(off6), CNT_W'(off6 + 7'd1)))
					icmp_seq_seen_q <= {icmp_seq_seen_q[7:0], b};
			end
		end
	end

	// Hold the last byte's position and tick until the decision is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_s1 <= 1'b0;
		end else if (item_acc && item.rx_last) begin
			pend_vld_s1 <= 1'b1;
		end else if (pend_take) begin
			pend_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc && item.rx_last) begin
			pend_pos_s1  <= byte_count_q;
			pend_big_s1  <= (byte_count_q >= CNT_W'(MAX_FRAME_BYTES));
			pend_tick_s1 <= item.now_tick;
		end
	end

	// Classify the frame from its captured fields
	always_comb begin
		logic [5:0]       hdr;
		logic [CMP_W-1:0] len_need;
		logic [16:0]      hdr_min;
		hdr      = {ip_header_words_q, 2'b00};
		len_need = CMP_W'(ip_total_length_q) + CMP_W'(13);
		hdr_min  = {11'd0, hdr} + 17'd8;
		action   = KIND_IGNORE;
		if (!pend_big_s1 && (pend_pos_s1 >= CNT_W'(13))) begin
			if (ether_type_q == ETHERTYPE_ARP) begin
				if ((pend_pos_s1 >= CNT_W'(41)) && (arp_hw_type_q == ARP_HW_ETH) &&
					(arp_proto_type_q == ETHERTYPE_IPV4)) begin
					if (arp_operation_q == ARP_OP_REQUEST) begin
						if (arp_target_ip_q == own_ip_q)
							action = KIND_REPLY;
					end else if (arp_operation_q == ARP_OP_REPLY) begin
						action = KIND_LEARN;
					end
				end
			end else if (ether_type_q == ETHERTYPE_IPV4) begin
				if ((pend_pos_s1 >= CNT_W'(33)) && (hdr >= 6'd20) &&
					(ip_protocol_q == IPPROTO_ICMP) &&
					(CMP_W'(pend_pos_s1) >= len_need) &&
					({1'b0, ip_total_length_q} >= hdr_min) &&
					(icmp_type_seen_q == ICMP_ECHO_REPLY))
					action = KIND_ECHO;
			end
		end
	end

	// Build the single result word
	always_comb begin
		single         = '0;
		single.kind    = action;
		single.tx_last = 1'b1;
		case (action)
			KIND_LEARN: begin
				single.peer_ip  = arp_sender_ip_q;
				single.peer_mac = arp_sender_mac_q;
			end
			KIND_ECHO: begin
				single.peer_ip    = ip_source_q;
				single.echo_ident = icmp_ident_seen_q;
				single.echo_seq   = icmp_seq_seen_q;
				single.rx_tick    = pend_tick_s1;
			end
			default: ;
		endcase
	end

	// Build the reply byte word from the top of the shift register
	always_comb begin
		rep_word         = '0;
		rep_word.kind    = KIND_REPLY;
		rep_word.tx_byte = rep_sr_q[REPLY_W-1 -: 8];
		rep_word.tx_last = (rep_cnt_q == RCNT_W'(1));
	end

	// Assemble the ARP reply frame, first wire byte on top
	assign reply_frame = {eth_source_mac_q, own_mac_q, ETHERTYPE_ARP, ARP_HW_ETH, ETHERTYPE_IPV4,
		ARP_HW_LEN, ARP_PROTO_LEN, ARP_OP_REPLY, own_mac_q, arp_target_ip_q,
		arp_sender_mac_q, arp_sender_ip_q};

	// Reply shift register and byte counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_cnt_q <= '0;
		end else if (pend_take && (action == KIND_REPLY)) begin
			rep_cnt_q <= RCNT_W'(REPLY_BYTES);
		end else if (rep_emit) begin
			rep_cnt_q <= rep_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_take && (action == KIND_REPLY)) begin
			rep_sr_q <= reply_frame;
		end else if (rep_emit) begin
			rep_sr_q <= {rep_sr_q[REPLY_W-9:0], 8'h00};
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (rep_emit || (pend_take && (action != KIND_REPLY))) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rep_emit) begin
			res_q <= rep_word;
		end else if (pend_take && (action != KIND_REPLY)) begin
			res_q <= single;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Checks
	a_stall_only_on_pend: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> pend_vld_s1)
		else $error("input stalled without a pending decision");

	a_rep_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		rep_cnt_q <= RCNT_W'(REPLY_BYTES))
		else $error("reply byte counter out of range");

	a_rep_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rep_busy) |-> $past(pend_vld_s1))
		else $error("reply started without a pending decision");

	a_rep_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rep_emit && (rep_cnt_q == RCNT_W'(1))) |=> (res_valid_q && res_q.tx_last))
		else $error("last reply byte not flagged");

endmodule
